FILE: design/dtsd_pkg.sv
`timescale 1ns / 1ps
package dtsd_pkg;

  // Field and result widths
  localparam int OUT_W = 56;
  localparam int DAYS_W = 24;
  localparam int TOTAL_W = 32;

  // Fixed point default
  localparam int FRACTION_BITS_DEF = 32;

  // Whole days that the time of day can carry (total_ms / one day < 64)
  localparam int QBITS = 6;

  // Quotient bits resolved per divider stage
  localparam int STEPS_PER_STAGE = 4;

  // Time constants in milliseconds
  localparam logic [TOTAL_W-1:0] MS_PER_DAY = 32'd86400000;
  localparam logic [31:0] MS_PER_HOUR = 32'd3600000;
  localparam logic [25:0] MS_PER_MIN = 26'd60000;
  localparam logic [25:0] SEC_LIMIT_MS = 26'd59000;

  // Year constants
  localparam logic [13:0] EPOCH_YEAR = 14'd1900;
  localparam logic [13:0] CENTURY_2000 = 14'd2000;
  localparam logic [13:0] SHORT_YEAR_SPLIT = 14'd30;
  localparam logic [DAYS_W-1:0] LEAPS_BEFORE_EPOCH = 24'd460;
  localparam logic [DAYS_W-1:0] PHANTOM_LEAP_DAY = 24'd59;

  // floor(y / 100) == (y * 5243) >> 19 for every 14 bit y
  localparam logic [26:0] DIV100_MUL = 27'd5243;
  localparam int DIV100_SHIFT = 19;

  // Period codes
  localparam logic [1:0] AMPM_NONE = 2'd0;
  localparam logic [1:0] AMPM_AM = 2'd1;
  localparam logic [1:0] AMPM_PM = 2'd2;
  localparam logic [1:0] AMPM_RSVD = 2'd3;

  // Side data that rides along the divider pipeline
  typedef struct packed {
    logic err;
    logic has_date;
    logic [DAYS_W-1:0] days;
  } dtsd_side_t;

  // Days in a month of a common year, zero for a bad month code
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    len = 5'd0;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of a common year before the first of the month
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    d = 9'd0;
    unique case (m)
      4'd1: d = 9'd0;
      4'd2: d = 9'd31;
      4'd3: d = 9'd59;
      4'd4: d = 9'd90;
      4'd5: d = 9'd120;
      4'd6: d = 9'd151;
      4'd7: d = 9'd181;
      4'd8: d = 9'd212;
      4'd9: d = 9'd243;
      4'd10: d = 9'd273;
      4'd11: d = 9'd304;
      4'd12: d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: design/dtsd_div_stage.sv
`timescale 1ns / 1ps
module dtsd_div_stage
  import dtsd_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int FIRST = 0,
  parameter int NSTEPS = STEPS_PER_STAGE
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  logic                             v_in,
  input  dtsd_side_t                       side_in,
  input  logic [TOTAL_W-1:0]               rem_in,
  input  logic [QBITS+FRACTION_BITS-1:0]   quo_in,
  output logic                             v_out,
  output dtsd_side_t                       side_out,
  output logic [TOTAL_W-1:0]               rem_out,
  output logic [QBITS+FRACTION_BITS-1:0]   quo_out
);

  localparam int QW = QBITS + FRACTION_BITS;

  logic [TOTAL_W-1:0] rem_next;
  logic [QW-1:0]      quo_next;
  logic [TOTAL_W-1:0] dsr;
  logic               qbit;

  // Resolve NSTEPS quotient bits: whole days first, then fraction bits
  always_comb begin
    rem_next = rem_in;
    quo_next = quo_in;
    dsr = MS_PER_DAY;
    qbit = 1'b0;
    for (int i = 0; i < NSTEPS; i++) begin
      if (FIRST + i < QBITS) begin
        dsr = MS_PER_DAY << ((FIRST + i < QBITS) ? (QBITS - 1 - FIRST - i) : 0);
      end else begin
        rem_next = rem_next << 1;
        dsr = MS_PER_DAY;
      end
      qbit = (rem_next >= dsr);
      if (qbit) begin
        rem_next = rem_next - dsr;
      end
      quo_next = {quo_next[QW-2:0], qbit};
    end
  end

  // Advance the stage when downstream has room
  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (load) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      side_out <= side_in;
      rem_out <= rem_next;
      quo_out <= quo_next;
    end
  end

endmodule

FILE: design/date_time_to_serial_day_core.sv
`timescale 1ns / 1ps
// Date and time to serial day number, 1900 date system. Each transaction
// carries one parsed date and time and yields one result: days since the
// epoch plus the day fraction in unsigned fixed point with FRACTION_BITS
// fraction bits, or valid_res low with a zero value on any field error.
// The pipeline takes one transaction per cycle and holds them under stall
// without loss. It has three stages of checks, products and date
// arithmetic, a restoring divider by one day that resolves up to four
// quotient bits per stage, and the output register. Values past the 56 bit
// range saturate to all ones and stay valid.
module date_time_to_serial_day_core
  import dtsd_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [13:0]        year,
  input  logic [3:0]         month,
  input  logic [5:0]         day,
  input  logic signed [10:0] hour,
  input  logic signed [10:0] minute,
  input  logic signed [26:0] second_ms,
  input  logic [1:0]         am_pm,
  input  logic               has_date,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [OUT_W-1:0]   serial_value,
  output logic               valid_res
);

  localparam int QW = QBITS + FRACTION_BITS;
  localparam int NDIV = (QW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int NS = NDIV + 4;
  localparam int INT_W = OUT_W - FRACTION_BITS;

  // Stage valids and load enables
  logic          va, vb, vc, vo;
  logic [NS-1:0] vall;
  logic [NS-1:0] go;

  // Stage A registers
  logic        a_err, a_has;
  logic [13:0] a_yw;
  logic [3:0]  a_month;
  logic [5:0]  a_day;
  logic [9:0]  a_hour, a_min;
  logic [25:0] a_sec;

  // Stage B registers
  logic              b_err, b_has;
  logic [13:0]       b_yw;
  logic [7:0]        b_c;
  logic [DAYS_W-1:0] b_ybase;
  logic [3:0]        b_month;
  logic [5:0]        b_day;
  logic [31:0]       b_phour;
  logic [25:0]       b_pmin;
  logic [25:0]       b_sec;

  // Stage C registers
  dtsd_side_t         c_side;
  logic [TOTAL_W-1:0] c_rem;

  // Divider chain
  logic               dv_c   [NDIV+1];
  dtsd_side_t         side_c [NDIV+1];
  logic [TOTAL_W-1:0] rem_c  [NDIV+1];
  logic [QW-1:0]      quo_c  [NDIV+1];

  // Stage A logic
  logic [9:0]  hu, mu;
  logic [25:0] su;
  logic        neg, min_over, sec_over, t_err;
  logic [9:0]  hour_adj;
  logic [13:0] yw;

  // Stage B logic
  logic [26:0] cmul;

  // Stage C logic
  logic              y4, y100, y400, leap;
  logic [5:0]        mlen;
  logic              d_err;
  logic [DAYS_W-1:0] lcount, days_calc;
  logic [TOTAL_W-1:0] total;

  // Output stage logic
  logic [QBITS-1:0]         q;
  logic [FRACTION_BITS-1:0] frac;
  logic [DAYS_W-1:0]        whole0, whole;
  logic [63:0]              whole_wide;
  logic                     sat;
  logic [OUT_W-1:0]         value;

  // Load enables: a stage loads when empty or when the next one loads
  always_comb begin
    vall = '0;
    vall[0] = va;
    vall[1] = vb;
    vall[2] = vc;
    for (int i = 0; i < NDIV; i++) begin
      vall[3+i] = dv_c[i+1];
    end
    vall[NS-1] = vo;
    go = '0;
    go[NS-1] = !vo || !out_stall;
    for (int s = NS - 2; s >= 0; s--) begin
      go[s] = !vall[s] || go[s+1];
    end
  end

  assign in_stall = !go[0];
  assign out_valid = vo;

  // Time checks, period rules and year widening
  always_comb begin
    hu = hour[9:0];
    mu = minute[9:0];
    su = second_ms[25:0];
    neg = hour[10] || minute[10] || second_ms[26];
    min_over = (mu > 10'd59);
    sec_over = (su > SEC_LIMIT_MS);
    t_err = neg || (min_over && sec_over) || ((hu > 10'd24) && (min_over || sec_over));
    hour_adj = hu;
    unique case (am_pm)
      AMPM_PM: begin
        if (hu < 10'd12) begin
          hour_adj = hu + 10'd12;
        end else if (hu > 10'd12) begin
          t_err = 1'b1;
        end
      end
      AMPM_AM: begin
        if (hu == 10'd12) begin
          hour_adj = 10'd0;
        end else if (hu > 10'd12) begin
          t_err = 1'b1;
        end
      end
      AMPM_NONE, AMPM_RSVD: begin
        hour_adj = hu;
      end
    endcase
    if ((year != 14'd0) && (year < SHORT_YEAR_SPLIT)) begin
      yw = year + CENTURY_2000;
    end else if ((year >= SHORT_YEAR_SPLIT) && (year < 14'd100)) begin
      yw = year + EPOCH_YEAR;
    end else begin
      yw = year;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (go[0]) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      a_err <= t_err;
      a_has <= has_date;
      a_yw <= yw;
      a_month <= month;
      a_day <= day;
      a_hour <= hour_adj;
      a_min <= mu;
      a_sec <= su;
    end
  end

  // Century quotient, year base days and time products
  assign cmul = 27'(a_yw) * DIV100_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (go[1]) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      b_err <= a_err;
      b_has <= a_has;
      b_yw <= a_yw;
      b_c <= cmul[DIV100_SHIFT+7:DIV100_SHIFT];
      b_ybase <= (DAYS_W'(a_yw) - DAYS_W'(EPOCH_YEAR)) * DAYS_W'(365);
      b_month <= a_month;
      b_day <= a_day;
      b_phour <= 32'(a_hour) * MS_PER_HOUR;
      b_pmin <= 26'(a_min) * MS_PER_MIN;
      b_sec <= a_sec;
    end
  end

  // Leap rule, date checks, day count and total milliseconds
  always_comb begin
    y4 = (b_yw[1:0] == 2'd0);
    y100 = (b_yw == 14'(15'(b_c) * 15'd100));
    y400 = y100 && (b_c[1:0] == 2'd0);
    leap = (y4 && !y100) || y400;
    mlen = 6'(month_len(b_month)) + 6'((b_month == 4'd2) && leap);
    d_err = (b_yw < EPOCH_YEAR) || (b_month < 4'd1) || (b_month > 4'd12)
            || (b_day > mlen);
    // leap years in 1 .. year-1, less those up to 1899
    lcount = DAYS_W'(b_yw >> 2) - DAYS_W'(y4)
           - (DAYS_W'(b_c) - DAYS_W'(y100))
           + (DAYS_W'(b_c >> 2) - DAYS_W'(y400))
           - LEAPS_BEFORE_EPOCH;
    days_calc = b_ybase + DAYS_W'(b_day) + lcount + DAYS_W'(days_before(b_month))
              + DAYS_W'((b_month > 4'd2) && leap);
    total = TOTAL_W'(b_sec) + TOTAL_W'(b_pmin) + b_phour;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (go[2]) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (go[2]) begin
      c_side.err <= b_err || (b_has && d_err);
      c_side.has_date <= b_has;
      c_side.days <= b_has ? days_calc : '0;
      c_rem <= total;
    end
  end

  assign dv_c[0] = vc;
  assign side_c[0] = c_side;
  assign rem_c[0] = c_rem;
  assign quo_c[0] = '0;

  // Divide total milliseconds by one day
  for (genvar i = 0; i < NDIV; i++) begin : g_div
    localparam int FIRST = i * STEPS_PER_STAGE;
    localparam int NST = (QW - FIRST < STEPS_PER_STAGE) ? (QW - FIRST) : STEPS_PER_STAGE;
    dtsd_div_stage #(
      .FRACTION_BITS(FRACTION_BITS),
      .FIRST(FIRST),
      .NSTEPS(NST)
    ) u_stage (
      .clk(clk),
      .rst(rst),
      .load(go[3+i]),
      .v_in(dv_c[i]),
      .side_in(side_c[i]),
      .rem_in(rem_c[i]),
      .quo_in(quo_c[i]),
      .v_out(dv_c[i+1]),
      .side_out(side_c[i+1]),
      .rem_out(rem_c[i+1]),
      .quo_out(quo_c[i+1])
    );
  end

  // Combine whole days, add the phantom leap day, saturate
  always_comb begin
    q = quo_c[NDIV][QW-1:FRACTION_BITS];
    frac = quo_c[NDIV][FRACTION_BITS-1:0];
    whole0 = side_c[NDIV].days + DAYS_W'(q);
    whole = whole0 + DAYS_W'(side_c[NDIV].has_date && (whole0 > PHANTOM_LEAP_DAY));
    whole_wide = 64'(whole);
    sat = ((whole_wide >> INT_W) != 64'd0);
    value = OUT_W'(whole_wide << FRACTION_BITS) | OUT_W'(frac);
    if (sat) begin
      value = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (go[NS-1]) begin
      vo <= dv_c[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (go[NS-1]) begin
      serial_value <= side_c[NDIV].err ? '0 : value;
      valid_res <= !side_c[NDIV].err;
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import dtsd_pkg::*;

  localparam int FRAC_BITS = FRACTION_BITS_DEF;
  localparam logic [OUT_W-1:0] SERIAL_MAX = {OUT_W{1'b1}};
  localparam logic [OUT_W-1:0] ONE_DAY = 56'd1 << FRAC_BITS;
  localparam logic [OUT_W-1:0] HALF_DAY = ONE_DAY >> 1;
  localparam int RANDOM_ITEMS = 1900;

  // One parsed date and time, as it goes into the block
  typedef struct {
    logic [13:0]        year;
    logic [3:0]         month;
    logic [5:0]         day;
    logic signed [10:0] hour;
    logic signed [10:0] minute;
    logic signed [26:0] second_ms;
    logic [1:0]         am_pm;
    logic               has_date;
  } stamp_t;

  // One serial day result
  typedef struct {
    logic [OUT_W-1:0] value;
    logic             ok;
  } serial_t;

  // Directed row: stimulus plus an optional hand-typed result
  typedef struct {
    stamp_t  stim;
    bit      typed;
    serial_t want;
  } stamp_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [13:0] year;
  logic [3:0] month;
  logic [5:0] day;
  logic signed [10:0] hour;
  logic signed [10:0] minute;
  logic signed [26:0] second_ms;
  logic [1:0] am_pm;
  logic has_date;
  logic out_valid;
  logic out_stall;
  logic [OUT_W-1:0] serial_value;
  logic valid_res;

  serial_t pending_serials[$];
  stamp_row_t stamp_rows[$];
  int mismatches;
  int sent_count;
  int good_results;
  int error_results;
  bit calm;

  date_time_to_serial_day_core #(
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .year(year),
    .month(month),
    .day(day),
    .hour(hour),
    .minute(minute),
    .second_ms(second_ms),
    .am_pm(am_pm),
    .has_date(has_date),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .serial_value(serial_value),
    .valid_res(valid_res)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gregorian leap year rule
  function automatic bit is_leap(input longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Leap years from year 1 through year n
  function automatic longint unsigned leaps_through(input longint unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  // Days in a month of a common year
  function automatic int common_month_days(input int m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11: return 30;
      2: return 28;
      default: return 0;
    endcase
  endfunction

  // Compute the serial day number for one date and time
  function automatic serial_t predict_serial(input stamp_t s);
    longint unsigned hr, mn, sec, total, q, r, frac, days, whole, y;
    int len;
    int m;
    bit leap;
    serial_t res;
    res.value = '0;
    res.ok = 1'b0;
    if (s.hour[10] || s.minute[10] || s.second_ms[26]) return res;
    hr = 64'(s.hour[9:0]);
    mn = 64'(s.minute[9:0]);
    sec = 64'(s.second_ms[25:0]);
    if (mn > 59 && sec > SEC_LIMIT_MS) return res;
    if (hr > 24 && (mn > 59 || sec > SEC_LIMIT_MS)) return res;

    // Fold the period into a 24 hour count
    if (s.am_pm == AMPM_PM) begin
      if (hr < 12) hr = hr + 12;
      else if (hr > 12) return res;
    end else if (s.am_pm == AMPM_AM) begin
      if (hr == 12) hr = 0;
      else if (hr > 12) return res;
    end

    // Whole days and truncated day fraction of the time
    total = sec + mn * MS_PER_MIN + hr * MS_PER_HOUR;
    q = total / MS_PER_DAY;
    r = total % MS_PER_DAY;
    frac = (r << FRAC_BITS) / MS_PER_DAY;

    // Days since the epoch for the date
    days = 0;
    if (s.has_date) begin
      y = 64'(s.year);
      if (y > 0 && y < SHORT_YEAR_SPLIT) y = y + CENTURY_2000;
      else if (y >= SHORT_YEAR_SPLIT && y < 100) y = y + EPOCH_YEAR;
      if (y < EPOCH_YEAR || s.month < 1 || s.month > 12) return res;
      leap = is_leap(y);
      len = common_month_days(int'(s.month));
      if (s.month == 2 && leap) len = 29;
      if (s.day > len) return res;
      days = (y - EPOCH_YEAR) * 365 + s.day + leaps_through(y - 1) - leaps_through(1899);
      for (m = 1; m < s.month; m++) begin
        days = days + common_month_days(m);
        if (m == 2 && leap) days = days + 1;
      end
    end

    // Skip the phantom leap day, then saturate
    whole = days + q;
    if (s.has_date && whole > PHANTOM_LEAP_DAY) whole = whole + 1;
    if (whole > (SERIAL_MAX >> FRAC_BITS)) res.value = SERIAL_MAX;
    else res.value = OUT_W'((whole << FRAC_BITS) | frac);
    res.ok = 1'b1;
    return res;
  endfunction

  // Append one directed row
  task automatic add_row(input int yr, input int mo, input int dy, input int hr,
                         input int mn, input int sec, input int ap, input int hd,
                         input bit typed, input logic [OUT_W-1:0] val, input bit ok);
    stamp_row_t row;
    row.stim.year = yr[13:0];
    row.stim.month = mo[3:0];
    row.stim.day = dy[5:0];
    row.stim.hour = hr[10:0];
    row.stim.minute = mn[10:0];
    row.stim.second_ms = sec[26:0];
    row.stim.am_pm = ap[1:0];
    row.stim.has_date = hd[0];
    row.typed = typed;
    row.want.value = val;
    row.want.ok = ok;
    stamp_rows.push_back(row);
  endtask

  // Drive one transaction and hold it until accepted
  task automatic send_stamp(input stamp_t s, input serial_t want);
    while (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    year <= s.year;
    month <= s.month;
    day <= s.day;
    hour <= s.hour;
    minute <= s.minute;
    second_ms <= s.second_ms;
    am_pm <= s.am_pm;
    has_date <= s.has_date;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_serials.push_back(want);
    sent_count++;
  endtask

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] exp);
    $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, exp);
    mismatches++;
  endtask

  // Stall the result side at random, except in the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 10);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    serial_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_serials.size() == 0) begin
        report_mismatch("unexpected result", serial_value, '0);
      end else begin
        want = pending_serials.pop_front();
        if (valid_res !== want.ok) begin
          report_mismatch("valid_res", OUT_W'(valid_res), OUT_W'(want.ok));
        end
        if (serial_value !== want.value) report_mismatch("serial_value", serial_value, want.value);
        if (want.ok) good_results++;
        else error_results++;
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    stamp_t s;
    serial_t want;
    int kind;
    int i;
    rst <= 1'b1;
    in_valid <= 1'b0;
    out_stall <= 1'b0;
    year <= '0;
    month <= '0;
    day <= '0;
    hour <= '0;
    minute <= '0;
    second_ms <= '0;
    am_pm <= AMPM_NONE;
    has_date <= 1'b0;
    calm <= 1'b0;
    mismatches = 0;
    sent_count = 0;
    good_results = 0;
    error_results = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: time checks, periods, date checks, phantom day, extremes
    add_row(0, 0, 0, 0, 0, 0, AMPM_NONE, 0, 1, '0, 1);
    add_row(0, 0, 0, -1, 0, 0, AMPM_NONE, 0, 1, '0, 0);
    add_row(0, 0, 0, 0, -1, 0, AMPM_NONE, 0, 1, '0, 0);
    add_row(0, 0, 0, 0, 0, -1, AMPM_NONE, 0, 1, '0, 0);
    add_row(0, 0, 0, 0, 60, 59001, AMPM_NONE, 0, 1, '0, 0);
    add_row(0, 0, 0, 25, 60, 0, AMPM_NONE, 0, 1, '0, 0);
    add_row(0, 0, 0, 25, 0, 59001, AMPM_NONE, 0, 1, '0, 0);
    add_row(0, 0, 0, 13, 0, 0, AMPM_PM, 0, 1, '0, 0);
    add_row(0, 0, 0, 13, 0, 0, AMPM_AM, 0, 1, '0, 0);
    add_row(0, 0, 0, 12, 0, 0, AMPM_AM, 0, 1, '0, 1);
    add_row(0, 0, 0, 11, 30, 1500, AMPM_PM, 0, 0, '0, 0);
    add_row(0, 0, 0, 30, 0, 0, AMPM_RSVD, 0, 0, '0, 0);
    add_row(1900, 0, 1, 0, 0, 0, AMPM_NONE, 1, 1, '0, 0);
    add_row(1900, 13, 1, 0, 0, 0, AMPM_NONE, 1, 1, '0, 0);
    add_row(1899, 1, 1, 0, 0, 0, AMPM_NONE, 1, 1, '0, 0);
    add_row(1900, 2, 29, 0, 0, 0, AMPM_NONE, 1, 1, '0, 0);
    add_row(1900, 1, 1, 0, 0, 0, AMPM_NONE, 1, 1, ONE_DAY, 1);
    add_row(1900, 2, 28, 12, 0, 0, AMPM_NONE, 1, 1, 59 * ONE_DAY + HALF_DAY, 1);
    add_row(1900, 3, 1, 0, 0, 0, AMPM_NONE, 1, 1, 61 * ONE_DAY, 1);
    add_row(1900, 2, 28, 24, 0, 0, AMPM_NONE, 1, 0, '0, 0);
    add_row(29, 2, 28, 0, 0, 0, AMPM_NONE, 1, 0, '0, 0);
    add_row(30, 12, 31, 23, 59, 59999, AMPM_NONE, 1, 0, '0, 0);
    add_row(2100, 2, 29, 0, 0, 0, AMPM_NONE, 1, 1, '0, 0);
    add_row(16383, 12, 31, 1023, 59, 59000, AMPM_NONE, 1, 0, '0, 0);
    add_row(16383, 15, 63, 0, 1023, 59000, AMPM_NONE, 0, 0, '0, 0);
    add_row(0, 0, 0, 0, 59, 67108863, AMPM_NONE, 0, 0, '0, 0);

    for (i = 0; i < stamp_rows.size(); i++) begin
      want = stamp_rows[i].typed ? stamp_rows[i].want : predict_serial(stamp_rows[i].stim);
      send_stamp(stamp_rows[i].stim, want);
    end

    // Random part: mostly well-formed dates and times, some edge times, some noise
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 700) calm <= 1'b1;
      if (i == 1100) calm <= 1'b0;
      kind = $urandom_range(99);
      if (kind < 85) begin
        case ($urandom_range(2))
          0: s.year = 14'($urandom_range(0, 99));
          1: s.year = 14'($urandom_range(1895, 2105));
          default: s.year = 14'($urandom_range(1900, 9999));
        endcase
        s.month = 4'($urandom_range(1, 12));
        s.day = 6'($urandom_range(0, 31));
        s.has_date = ($urandom_range(9) != 0);
        s.am_pm = 2'($urandom_range(3));
        if (kind < 70) begin
          s.hour = (s.am_pm == AMPM_AM || s.am_pm == AMPM_PM) ?
                   11'($urandom_range(0, 12)) : 11'($urandom_range(0, 24));
          s.minute = 11'($urandom_range(0, 59));
          s.second_ms = 27'($urandom_range(0, 59999));
        end else begin
          s.hour = 11'($urandom_range(0, 1023));
          s.minute = 11'($urandom_range(0, 120));
          s.second_ms = 27'($urandom_range(0, 70000));
        end
      end else begin
        s.year = 14'($urandom);
        s.month = 4'($urandom);
        s.day = 6'($urandom);
        s.hour = 11'($urandom);
        s.minute = 11'($urandom);
        s.second_ms = 27'($urandom);
        s.am_pm = 2'($urandom);
        s.has_date = 1'($urandom);
      end
      send_stamp(s, predict_serial(s));
    end
    in_valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (pending_serials.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d date and time transactions: %0d good serial days, %0d error results.",
             sent_count, good_results, error_results);
    $display("Covered field checks, AM and PM folding, short years, leap days and the phantom day.");
    if (mismatches == 0 && pending_serials.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
